>>> rtl/gcpg_pkg.sv
// shared types, constants and root functions for the gamma curve point generator
package gcpg_pkg;

    // default sizes
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int POINT_COUNT_DEF = 1024;

    // fixed field widths
    localparam int IDX_W  = 10;
    localparam int POS_W  = 17;
    localparam int CFG_W  = 16;
    localparam int FRAC_W = 16;
    localparam int M_W    = 31;
    localparam int BASE_W = 21;
    localparam int Q_W    = 33;
    localparam int IP_W   = 5;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // fixed-point anchors
    localparam logic [POS_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [M_W-1:0]   ONE_Q30 = 31'h4000_0000;

    // register reset values
    localparam logic [CFG_W-1:0] GAMMA_RST = 16'd4096;
    localparam logic [CFG_W-1:0] UNITY_RST = 16'd16384;
    localparam int               CEIL_RST  = 16384;

    // register indexes
    typedef enum logic [2:0] {
        REG_GAMMA      = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_CONTRAST   = 3'd2,
        REG_BAL_RED    = 3'd3,
        REG_BAL_GREEN  = 3'd4,
        REG_BAL_BLUE   = 3'd5,
        REG_FLOOR      = 3'd6,
        REG_CEILING    = 3'd7
    } t_reg_idx;

    // control tag travelling with every word
    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // truncated integer square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] b;
        r   = '0;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // r_k = 2^(-2^-k) in Q.30 by repeated square roots of 0.5
    function automatic logic [M_W-1:0] exp_root(input int k);
        logic [63:0] prev;
        prev = 64'h2000_0000;
        for (int j = 1; j <= k; j++) begin
            prev = isqrt64(prev << 30);
        end
        return prev[M_W-1:0];
    endfunction

endpackage

>>> rtl/gamma_curve_point_generator.sv
// gamma curve point generator: normalize, log2 cells, divide cells, exp2 cells, level tail
// throughput: one point per cycle; busy is never raised, every cell advances each cycle
// latency is set by the 16 log2 cells, 33 divide cells, 16 exp2 cells and 8 other stages
// reset: i_rst_n synchronous active low clears all valid bits and loads register defaults
// results leave on o_valid for one cycle; the receiver cannot stall them
module gamma_curve_point_generator #(
    parameter int LEVEL_BITS  = gcpg_pkg::LEVEL_BITS_DEF,
    parameter int POINT_COUNT = gcpg_pkg::POINT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gcpg_pkg::IDX_W-1:0]          i_point_index,
    input  logic [gcpg_pkg::POS_W-1:0]          i_point_position,
    output logic                                o_valid,
    output logic [gcpg_pkg::IDX_W-1:0]          o_entry_index,
    output logic signed [LEVEL_BITS-1:0]        o_red_level,
    output logic signed [LEVEL_BITS-1:0]        o_green_level,
    output logic signed [LEVEL_BITS-1:0]        o_blue_level,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gcpg_pkg::ADDR_W-1:0]         paddr,
    input  logic [gcpg_pkg::DATA_W-1:0]         pwdata,
    output logic [gcpg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    localparam int LB    = LEVEL_BITS;
    localparam int C16W  = 21;
    localparam int CNW   = 36;
    localparam int DW    = LB + 1;
    localparam int PDW   = C16W + DW;
    localparam int TW    = PDW + 1;
    localparam int T22W  = TW - 8;
    localparam int PW    = T22W + 17;
    localparam int LVW   = PW - 22;
    localparam int NLOG  = gcpg_pkg::FRAC_W;
    localparam int NDIV  = gcpg_pkg::Q_W;
    localparam int NEXP  = gcpg_pkg::FRAC_W;
    localparam int LAT   = 1 + NLOG + NDIV + NEXP + 7;

    // ---------------- configuration registers ----------------
    logic [gcpg_pkg::CFG_W-1:0] r_gamma, r_bri, r_con, r_bal_r, r_bal_g, r_bal_b;
    logic [LB-1:0]              r_floor, r_ceil;
    gcpg_pkg::t_reg_idx         reg_sel;
    logic                       cfg_wr;

    assign reg_sel = gcpg_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= gcpg_pkg::GAMMA_RST;
            r_bri   <= gcpg_pkg::UNITY_RST;
            r_con   <= gcpg_pkg::UNITY_RST;
            r_bal_r <= gcpg_pkg::UNITY_RST;
            r_bal_g <= gcpg_pkg::UNITY_RST;
            r_bal_b <= gcpg_pkg::UNITY_RST;
            r_floor <= '0;
            r_ceil  <= LB'(gcpg_pkg::CEIL_RST);
        end else if (cfg_wr) begin
            case (reg_sel)
                gcpg_pkg::REG_GAMMA:      r_gamma <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_BRIGHTNESS: r_bri   <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_CONTRAST:   r_con   <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_BAL_RED:    r_bal_r <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_BAL_GREEN:  r_bal_g <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_BAL_BLUE:   r_bal_b <= pwdata[gcpg_pkg::CFG_W-1:0];
                gcpg_pkg::REG_FLOOR:      r_floor <= pwdata[LB-1:0];
                gcpg_pkg::REG_CEILING:    r_ceil  <= pwdata[LB-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_sel)
            gcpg_pkg::REG_GAMMA:      prdata = gcpg_pkg::DATA_W'(r_gamma);
            gcpg_pkg::REG_BRIGHTNESS: prdata = gcpg_pkg::DATA_W'(r_bri);
            gcpg_pkg::REG_CONTRAST:   prdata = gcpg_pkg::DATA_W'(r_con);
            gcpg_pkg::REG_BAL_RED:    prdata = gcpg_pkg::DATA_W'(r_bal_r);
            gcpg_pkg::REG_BAL_GREEN:  prdata = gcpg_pkg::DATA_W'(r_bal_g);
            gcpg_pkg::REG_BAL_BLUE:   prdata = gcpg_pkg::DATA_W'(r_bal_b);
            gcpg_pkg::REG_FLOOR:      prdata = gcpg_pkg::DATA_W'(r_floor);
            gcpg_pkg::REG_CEILING:    prdata = gcpg_pkg::DATA_W'(r_ceil);
            default:                  prdata = '0;
        endcase
    end

    // effective gamma, zero guarded to one lsb
    logic [gcpg_pkg::CFG_W-1:0] g_eff;
    assign g_eff = (r_gamma == '0) ? gcpg_pkg::CFG_W'(1) : r_gamma;

    // ---------------- front: saturate and normalize ----------------
    logic [gcpg_pkg::POS_W-1:0]  pos_sat;
    logic [4:0]                  msb_n;
    gcpg_pkg::t_tag              n_tag0;
    logic [gcpg_pkg::M_W-1:0]    n_m0;
    logic [gcpg_pkg::BASE_W-1:0] n_base0;

    always_comb begin
        pos_sat = (i_point_position > gcpg_pkg::ONE_Q16) ? gcpg_pkg::ONE_Q16 : i_point_position;
        msb_n   = '0;
        for (int i = 0; i < gcpg_pkg::POS_W; i++) begin
            if (pos_sat[i]) msb_n = 5'(i);
        end
        n_m0       = {14'd0, pos_sat} << (5'd30 - msb_n);
        n_base0    = {5'(5'd16 - msb_n), 16'd0};
        n_tag0.vld  = start && !busy;
        n_tag0.zero = (pos_sat == '0);
        n_tag0.idx  = i_point_index;
    end

    gcpg_pkg::t_tag              log_tag  [0:NLOG];
    logic [gcpg_pkg::M_W-1:0]    log_m    [0:NLOG];
    logic [gcpg_pkg::FRAC_W-1:0] log_frac [0:NLOG];
    logic [gcpg_pkg::BASE_W-1:0] log_base [0:NLOG];
    gcpg_pkg::t_tag              r_tag0;
    logic [gcpg_pkg::M_W-1:0]    r_m0;
    logic [gcpg_pkg::BASE_W-1:0] r_base0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
        end else begin
            r_tag0 <= n_tag0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0    <= n_m0;
        r_base0 <= n_base0;
    end

    assign log_tag[0]  = r_tag0;
    assign log_m[0]    = r_m0;
    assign log_frac[0] = '0;
    assign log_base[0] = r_base0;

    // ---------------- log2 chain ----------------
    for (genvar k = 1; k <= NLOG; k++) begin : g_log
        gcpg_log_cell #(
            .STEP        (k),
            .POINT_COUNT (POINT_COUNT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (log_tag[k-1]),
            .i_m     (log_m[k-1]),
            .i_frac  (log_frac[k-1]),
            .i_base  (log_base[k-1]),
            .o_tag   (log_tag[k]),
            .o_m     (log_m[k]),
            .o_frac  (log_frac[k]),
            .o_base  (log_base[k])
        );
    end

    // ---------------- divide chain: E = (D*4096 + g/2) / g ----------------
    logic [gcpg_pkg::BASE_W-1:0] log_mag;
    logic [gcpg_pkg::Q_W-1:0]    numer;

    assign log_mag = log_base[NLOG] - gcpg_pkg::BASE_W'(log_frac[NLOG]);
    assign numer   = {log_mag, 12'd0} + gcpg_pkg::Q_W'(g_eff >> 1);

    gcpg_pkg::t_tag              div_tag [0:NDIV];
    logic [gcpg_pkg::CFG_W-1:0]  div_rem [0:NDIV];
    logic [gcpg_pkg::Q_W-1:0]    div_q   [0:NDIV];

    assign div_tag[0] = log_tag[NLOG];
    assign div_rem[0] = '0;
    assign div_q[0]   = numer;

    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        gcpg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (div_tag[k-1]),
            .i_rem   (div_rem[k-1]),
            .i_q     (div_q[k-1]),
            .i_g     (g_eff),
            .o_tag   (div_tag[k]),
            .o_rem   (div_rem[k]),
            .o_q     (div_q[k])
        );
    end

    // ---------------- exp2 chain ----------------
    gcpg_pkg::t_tag              exp_tag [0:NEXP];
    logic [gcpg_pkg::M_W-1:0]    exp_p   [0:NEXP];
    logic [gcpg_pkg::FRAC_W-1:0] exp_fr  [0:NEXP];
    logic [gcpg_pkg::IP_W-1:0]   exp_ip  [0:NEXP];
    logic                        tiny;

    // integer part of 17 or more leaves nothing
    assign tiny = (div_q[NDIV][gcpg_pkg::Q_W-1:16] >= 17'd17);

    always_comb begin
        exp_tag[0]      = div_tag[NDIV];
        exp_tag[0].zero = div_tag[NDIV].zero || tiny;
    end
    assign exp_p[0]  = gcpg_pkg::ONE_Q30;
    assign exp_fr[0] = div_q[NDIV][gcpg_pkg::FRAC_W-1:0];
    assign exp_ip[0] = div_q[NDIV][20:16];

    for (genvar k = 1; k <= NEXP; k++) begin : g_exp
        gcpg_exp_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (exp_tag[k-1]),
            .i_p     (exp_p[k-1]),
            .i_fr    (exp_fr[k-1]),
            .i_ip    (exp_ip[k-1]),
            .o_tag   (exp_tag[k]),
            .o_p     (exp_p[k]),
            .o_fr    (exp_fr[k]),
            .o_ip    (exp_ip[k])
        );
    end

    // ---------------- tail stages ----------------
    gcpg_pkg::t_tag r_tag_a, r_tag_b, r_tag_c, r_tag_d, r_tag_e, r_tag_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
            r_tag_d <= '0;
            r_tag_e <= '0;
            r_tag_f <= '0;
        end else begin
            r_tag_a <= exp_tag[NEXP];
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
            r_tag_d <= r_tag_c;
            r_tag_e <= r_tag_d;
            r_tag_f <= r_tag_e;
        end
    end

    // stage a: round-shift to Q1.16
    logic [4:0]                 sh;
    logic [31:0]                rsum;
    logic [gcpg_pkg::POS_W-1:0] r_y, n_y;
    always_comb begin
        sh   = 5'd14 + exp_ip[NEXP];
        rsum = {1'b0, exp_p[NEXP]} + (32'd1 << (sh - 5'd1));
        n_y  = exp_tag[NEXP].zero ? '0 : gcpg_pkg::POS_W'(rsum >> sh);
    end

    // stage b: contrast gain product
    logic [gcpg_pkg::CFG_W:0] con_gain;
    logic [33:0]              r_cprod;
    assign con_gain = {1'b0, r_con} + 17'd16384;

    // stage c: affine sum, floor to Q.16
    logic [gcpg_pkg::CFG_W:0]  bc_diff;
    logic signed [CNW-1:0]     cn;
    logic signed [C16W-1:0]    r_c16;
    always_comb begin
        bc_diff = {1'b0, r_bri} - {1'b0, r_con};
        cn      = $signed({2'b00, r_cprod})
                + ($signed({{(CNW-17){bc_diff[16]}}, bc_diff}) <<< 15);
    end

    // stage d: span product
    logic signed [DW-1:0]  span;
    logic signed [PDW-1:0] r_sprod;
    assign span = $signed({r_ceil[LB-1], r_ceil}) - $signed({r_floor[LB-1], r_floor});

    // stage e: add floor, floor to Q.22
    logic signed [TW-1:0]   tsum;
    logic signed [T22W-1:0] r_t22;
    assign tsum = ($signed({{(TW-LB){r_floor[LB-1]}}, r_floor}) <<< 16)
                + $signed({r_sprod[PDW-1], r_sprod});

    // stage f: balance products
    logic signed [PW-1:0] r_pr, r_pg, r_pb;

    always_ff @(posedge i_clk) begin
        r_y     <= n_y;
        r_cprod <= con_gain * r_y;
        r_c16   <= cn[CNW-1:15];
        r_sprod <= PDW'(r_c16) * PDW'(span);
        r_t22   <= tsum[TW-1:8];
        r_pr    <= PW'(r_t22) * $signed({{(PW-17){1'b0}}, 1'b0, r_bal_r});
        r_pg    <= PW'(r_t22) * $signed({{(PW-17){1'b0}}, 1'b0, r_bal_g});
        r_pb    <= PW'(r_t22) * $signed({{(PW-17){1'b0}}, 1'b0, r_bal_b});
    end

    // stage g: round to Q.14 and clamp
    logic signed [LVW-1:0] lo_x, hi_x;
    assign lo_x = LVW'($signed(r_floor));
    assign hi_x = LVW'($signed(r_ceil));

    function automatic logic [LB-1:0] round_clamp(
        input logic signed [PW-1:0]  p,
        input logic signed [LVW-1:0] lo,
        input logic signed [LVW-1:0] hi
    );
        logic signed [PW-1:0]  s;
        logic signed [LVW-1:0] lev;
        s   = p + (PW'(1) <<< 21);
        lev = s[PW-1:22];
        if (lev < lo) lev = lo;
        else if (lev > hi) lev = hi;
        return lev[LB-1:0];
    endfunction

    logic                      r_valid;
    logic [gcpg_pkg::IDX_W-1:0] r_idx;
    logic [LB-1:0]             r_red, r_green, r_blue;

    // valid and index ride alongside the level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_tag_f.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= r_tag_f.idx;
        r_red   <= round_clamp(r_pr, lo_x, hi_x);
        r_green <= round_clamp(r_pg, lo_x, hi_x);
        r_blue  <= round_clamp(r_pb, lo_x, hi_x);
    end

    assign o_valid       = r_valid;
    assign o_entry_index = r_idx;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

`ifndef SYNTHESIS
    // every word comes from an accepted start
    a_out_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("word without matching start");

    // every accepted start yields a word on o_valid
    a_start_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted point lost");

    // with an ordered span the red and blue levels stay inside it
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($signed(r_floor) <= $signed(r_ceil))) |->
        ($signed(o_red_level) >= $signed(r_floor) && $signed(o_red_level) <= $signed(r_ceil)
        && $signed(o_blue_level) >= $signed(r_floor)
        && $signed(o_blue_level) <= $signed(r_ceil)))
        else $error("level outside span");
`endif
endmodule

>>> rtl/gcpg_log_cell.sv
// one square-and-test step of the log2 chain, also one step of index reduction
module gcpg_log_cell #(
    parameter int STEP        = 1,
    parameter int POINT_COUNT = gcpg_pkg::POINT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gcpg_pkg::t_tag                  i_tag,
    input  logic [gcpg_pkg::M_W-1:0]        i_m,
    input  logic [gcpg_pkg::FRAC_W-1:0]     i_frac,
    input  logic [gcpg_pkg::BASE_W-1:0]     i_base,
    output gcpg_pkg::t_tag                  o_tag,
    output logic [gcpg_pkg::M_W-1:0]        o_m,
    output logic [gcpg_pkg::FRAC_W-1:0]     o_frac,
    output logic [gcpg_pkg::BASE_W-1:0]     o_base
);
    localparam int          BIT    = gcpg_pkg::FRAC_W - STEP;
    localparam int unsigned SUB    = POINT_COUNT << BIT;
    localparam bit          DO_SUB = (SUB < (1 << gcpg_pkg::IDX_W));
    localparam logic [gcpg_pkg::IDX_W-1:0] SUB_V = DO_SUB ? gcpg_pkg::IDX_W'(SUB) : '0;

    gcpg_pkg::t_tag                  r_tag,  n_tag;
    logic [gcpg_pkg::M_W-1:0]        r_m,    n_m;
    logic [gcpg_pkg::FRAC_W-1:0]     r_frac, n_frac;
    logic [gcpg_pkg::BASE_W-1:0]     r_base;
    logic [2*gcpg_pkg::M_W-1:0]      sq_full;
    logic [gcpg_pkg::M_W:0]          sq;

    // square, renormalize, record fraction bit
    always_comb begin
        sq_full = {{gcpg_pkg::M_W{1'b0}}, i_m} * {{gcpg_pkg::M_W{1'b0}}, i_m};
        sq      = sq_full[2*gcpg_pkg::M_W-1:30];
        n_frac  = i_frac;
        if (sq[gcpg_pkg::M_W]) begin
            n_m         = sq[gcpg_pkg::M_W:1];
            n_frac[BIT] = 1'b1;
        end else begin
            n_m = sq[gcpg_pkg::M_W-1:0];
        end
        // one restoring step of index modulo point count
        n_tag = i_tag;
        if (DO_SUB && (i_tag.idx >= SUB_V)) begin
            n_tag.idx = i_tag.idx - SUB_V;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_frac <= n_frac;
        r_base <= i_base;
    end

    assign o_tag  = r_tag;
    assign o_m    = r_m;
    assign o_frac = r_frac;
    assign o_base = r_base;
endmodule

>>> rtl/gcpg_div_cell.sv
// one restoring division step of the exponent divide
module gcpg_div_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcpg_pkg::t_tag                i_tag,
    input  logic [gcpg_pkg::CFG_W-1:0]    i_rem,
    input  logic [gcpg_pkg::Q_W-1:0]      i_q,
    input  logic [gcpg_pkg::CFG_W-1:0]    i_g,
    output gcpg_pkg::t_tag                o_tag,
    output logic [gcpg_pkg::CFG_W-1:0]    o_rem,
    output logic [gcpg_pkg::Q_W-1:0]      o_q
);
    gcpg_pkg::t_tag                 r_tag;
    logic [gcpg_pkg::CFG_W-1:0]     r_rem, n_rem;
    logic [gcpg_pkg::Q_W-1:0]       r_q,   n_q;
    logic [gcpg_pkg::CFG_W:0]       rs;
    logic [gcpg_pkg::CFG_W:0]       diff;
    logic                           ge;

    // shift in next numerator bit, subtract if it fits
    always_comb begin
        rs    = {i_rem, i_q[gcpg_pkg::Q_W-1]};
        diff  = rs - {1'b0, i_g};
        ge    = (rs >= {1'b0, i_g});
        n_rem = ge ? diff[gcpg_pkg::CFG_W-1:0] : rs[gcpg_pkg::CFG_W-1:0];
        n_q   = {i_q[gcpg_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

>>> rtl/gcpg_exp_cell.sv
// one conditional root multiply of the exp2 chain
module gcpg_exp_cell #(
    parameter int STEP = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gcpg_pkg::t_tag                 i_tag,
    input  logic [gcpg_pkg::M_W-1:0]       i_p,
    input  logic [gcpg_pkg::FRAC_W-1:0]    i_fr,
    input  logic [gcpg_pkg::IP_W-1:0]      i_ip,
    output gcpg_pkg::t_tag                 o_tag,
    output logic [gcpg_pkg::M_W-1:0]       o_p,
    output logic [gcpg_pkg::FRAC_W-1:0]    o_fr,
    output logic [gcpg_pkg::IP_W-1:0]      o_ip
);
    localparam logic [gcpg_pkg::M_W-1:0] ROOT = gcpg_pkg::exp_root(STEP);
    localparam int BIT = gcpg_pkg::FRAC_W - STEP;

    gcpg_pkg::t_tag                  r_tag;
    logic [gcpg_pkg::M_W-1:0]        r_p, n_p;
    logic [gcpg_pkg::FRAC_W-1:0]     r_fr;
    logic [gcpg_pkg::IP_W-1:0]       r_ip;
    logic [2*gcpg_pkg::M_W-1:0]      prod;

    // multiply by this step's root when its exponent bit is set
    always_comb begin
        prod = {{gcpg_pkg::M_W{1'b0}}, i_p} * {{gcpg_pkg::M_W{1'b0}}, ROOT};
        n_p  = i_fr[BIT] ? prod[gcpg_pkg::M_W+29:30] : i_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= n_p;
        r_fr <= i_fr;
        r_ip <= i_ip;
    end

    assign o_tag = r_tag;
    assign o_p   = r_p;
    assign o_fr  = r_fr;
    assign o_ip  = r_ip;
endmodule
